### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### sv/fibmp_pkg.sv
`timescale 1ns / 1ps
package fibmp_pkg;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;
  localparam logic [VAL_W-1:0] N_ONE_ANSWER = 31'd2;
  typedef logic [VAL_W-1:0] val_t;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mm_ctl_t;
endpackage

### sv/fibmp_mulmod.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Modular multiplier: one registered 31x31 product, then restoring
// reduction of the product, one quotient bit per cycle.
module fibmp_mulmod
  import fibmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  val_t    a,
  input  val_t    b,
  input  val_t    m,
  output logic    busy,
  output logic    done,
  output val_t    res
);
  localparam int unsigned CNT_W = $clog2(PROD_W + 2);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RED} state_t;

  state_t              state_r;
  logic [PROD_W-1:0]   prod_r;
  logic [VAL_W:0]      rem_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                done_r;
  logic [VAL_W+1:0]    shifted;
  logic [VAL_W+1:0]    diff;

  // One restoring step: shift in the next product bit, subtract if it fits
  assign shifted = {rem_r, prod_r[PROD_W-1]};
  assign diff = shifted - {2'b00, m};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            prod_r  <= PROD_W'(a) * PROD_W'(b);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          rem_r   <= '0;
          cnt_r   <= CNT_W'(PROD_W);
          state_r <= S_RED;
        end
        S_RED: begin
          prod_r <= {prod_r[PROD_W-2:0], 1'b0};
          if (!diff[VAL_W+1]) rem_r <= diff[VAL_W:0];
          else rem_r <= shifted[VAL_W:0];
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign res  = rem_r[VAL_W-1:0];

  `ASSERT_CLK(a_done_idle, clk, rst_n, done |-> !busy)
  `ASSERT_CLK(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
  `ASSERT_CLK(a_rem_range, clk, rst_n, (state_r == S_RED) |-> (rem_r < {1'b0, m}))
endmodule

### sv/fibonacci_mod_matrix_power.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel  | ports                          | handshake
// input    | in_index                       | start & !busy
// result   | out_value                      | out_valid, one cycle
// config   | cfg_modulus                    | cfg_valid & cfg_ready
// One multiply-reduce on the shared unit runs issue, product, 62 reduction
// steps and done; a matrix product is 8 of them, followed by the S_NEXT step.
// Each bit of n+2 costs one squaring pass plus one multiply pass per set bit.
// n of 0 or 1, or a zero modulus: no matrix passes; the block goes from idle straight to S_OUT.
// Reset is synchronous, active low; modulus returns to 1000000007.
// Results appear for one cycle and cannot be stalled.
module fibonacci_mod_matrix_power
  import fibmp_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = 62
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [INDEX_WIDTH-1:0] in_index,
  output logic                   out_valid,
  output logic [VAL_W-1:0]       out_value,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VAL_W-1:0]       cfg_modulus
);
  localparam int unsigned EXP_W = INDEX_WIDTH + 1;

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_ISSUE, S_WAIT, S_NEXT,
                            S_OUT} state_t;

  state_t            state_r;
  val_t              mod_r;
  logic [EXP_W-1:0]  exp_r;
  val_t              acc_r [4];
  val_t              base_r [4];
  val_t              tmp_r [4];
  val_t              part_r;
  logic [2:0]        op_r;
  logic              sq_r;
  val_t              value_r;
  logic              out_valid_r;
  val_t              one_m;
  val_t              ma, mb, mres, sum;
  logic [VAL_W:0]    sum_w;
  logic              mul_start, mul_busy, mul_done;
  logic [1:0]        ei;

  assign one_m = (mod_r == VAL_W'(1)) ? '0 : VAL_W'(1);

  // Operand pick: entry ei = {i,j}; op bit0 selects k
  assign ei = op_r[2:1];
  always_comb begin
    if (sq_r) begin
      ma = base_r[{ei[1], op_r[0]}];
      mb = base_r[{op_r[0], ei[0]}];
    end else begin
      ma = acc_r[{ei[1], op_r[0]}];
      mb = base_r[{op_r[0], ei[0]}];
    end
  end

  // Modular add of two partial products
  assign sum_w = {1'b0, part_r} + {1'b0, mres};
  assign sum = (sum_w >= {1'b0, mod_r}) ? val_t'(sum_w - {1'b0, mod_r})
                                         : sum_w[VAL_W-1:0];

  assign mul_start = (state_r == S_ISSUE);

  fibmp_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(ma), .b(mb),
    .m(mod_r), .busy(mul_busy), .done(mul_done), .res(mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      // take a configuration transaction while idle and no item arrives
      if (cfg_valid && cfg_ready) mod_r <= cfg_modulus;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            exp_r <= EXP_W'(in_index) + EXP_W'(2);
            if (in_index == '0) begin
              value_r <= '0;
              state_r <= S_OUT;
            end else if (in_index == INDEX_WIDTH'(1)) begin
              value_r <= N_ONE_ANSWER;
              state_r <= S_OUT;
            end else if (mod_r == '0) begin
              value_r <= '0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_INIT;
            end
          end
        end
        S_INIT: begin
          acc_r[0]  <= one_m; acc_r[1] <= '0; acc_r[2] <= '0; acc_r[3] <= one_m;
          base_r[0] <= one_m; base_r[1] <= one_m;
          base_r[2] <= one_m; base_r[3] <= '0;
          op_r <= '0;
          sq_r <= ~exp_r[0];
          state_r <= S_ISSUE;
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (!op_r[0]) part_r <= mres;
            else tmp_r[ei] <= sum;
            op_r <= op_r + 3'd1;
            if (op_r == 3'd7) state_r <= S_NEXT;
            else state_r <= S_ISSUE;
          end
        end
        S_NEXT: begin
          op_r <= '0;
          if (!sq_r) begin
            // multiply pass done, square next
            acc_r   <= tmp_r;
            sq_r    <= 1'b1;
            state_r <= S_ISSUE;
          end else begin
            base_r <= tmp_r;
            exp_r  <= exp_r >> 1;
            if ((exp_r >> 1) == '0) begin
              value_r <= acc_r[0];
              state_r <= S_OUT;
            end else begin
              sq_r    <= ~exp_r[1];
              state_r <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_value = value_r;

  `ASSERT_CLK(a_one_result, clk, rst_n, out_valid |=> !out_valid)
  `ASSERT_CLK(a_mul_only_work, clk, rst_n, mul_busy |-> busy)
  `ASSERT_CLK(a_take_busy, clk, rst_n, (start && !busy) |=> busy)
endmodule
